FILE: rtl/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = 2 * DATA_WIDTH + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         divide_by_zero;
  } cau_out_t;

  // Side information that rides along the divider pipeline.
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic                  ovf;
    logic [DATA_WIDTH-1:0] re;
    logic [DATA_WIDTH-1:0] im;
  } cau_side_t;

  // Saturates a signed value to the data width; the top bit is the saturation flag.
  function automatic logic [DATA_WIDTH:0] cau_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo = -SUM_W'({1'b1, {(DATA_WIDTH-1){1'b0}}});
    if (v > hi) begin
      return {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
    end
    return {1'b0, v[DATA_WIDTH-1:0]};
  endfunction

  // One restoring division step; the top bit is the quotient bit.
  function automatic logic [PROD_W:0] cau_step(input logic [PROD_W-1:0] rem,
                                               input logic             nbit,
                                               input logic [PROD_W-1:0] den);
    logic [PROD_W:0] r2;
    r2 = {rem, nbit};
    if (r2 >= {1'b0, den}) begin
      r2 = r2 - {1'b0, den};
      return {1'b1, r2[PROD_W-1:0]};
    end
    return {1'b0, r2[PROD_W-1:0]};
  endfunction

endpackage

FILE: rtl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: add, subtract, multiply and divide.
//
// The unit takes one transfer of two signed fixed-point complex operands and an
// operation code per clock and returns one result transfer per operand pair, in
// order. Sustained rate is one item per cycle while the output is not stalled.
// The pipeline is the operand register with the six multipliers, the sum stage,
// the rescale/divide-setup stage, the divider stages that retire four quotient
// bits each, and the output register. Every item runs through the same depth, so
// results leave in arrival order. When a result waits on a stalled output the
// whole pipeline holds and in_stall is raised. Products are rescaled by an
// arithmetic shift (floor), quotients truncate toward zero, each part saturates
// with overflow set, and a divide by zero returns zero parts with divide_by_zero
// set.
module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS_P = FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cau_out_t out_data
);

  localparam int W   = DATA_WIDTH;
  localparam int DXW = SUM_W + FRAC_BITS_P;
  localparam int CW  = DXW + W;

  // The pipeline advances when the output register is free or being drained.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: operand products and the add/subtract sums.
  logic                     s1_valid_r;
  logic [1:0]               s1_kind_r;
  logic                     s1_dz_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, q_rr_r, q_ii_r;
  logic signed [W:0]        as_re_r, as_im_r;

  logic signed [PROD_W-1:0] ar, ai, br, bi;
  assign ar = PROD_W'(in_data.a_re);
  assign ai = PROD_W'(in_data.a_im);
  assign br = PROD_W'(in_data.b_re);
  assign bi = PROD_W'(in_data.b_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= in_data.kind;
      s1_dz_r   <= (in_data.kind == OP_DIV) && (in_data.b_re == '0) && (in_data.b_im == '0);
      p_rr_r    <= ar * br;
      p_ii_r    <= ai * bi;
      p_ri_r    <= ar * bi;
      p_ir_r    <= ai * br;
      q_rr_r    <= br * br;
      q_ii_r    <= bi * bi;
      if (in_data.kind == OP_SUB) begin
        as_re_r <= (W+1)'(in_data.a_re) - (W+1)'(in_data.b_re);
        as_im_r <= (W+1)'(in_data.a_im) - (W+1)'(in_data.b_im);
      end else begin
        as_re_r <= (W+1)'(in_data.a_re) + (W+1)'(in_data.b_re);
        as_im_r <= (W+1)'(in_data.a_im) + (W+1)'(in_data.b_im);
      end
    end
  end

  // Stage 2: combine the products into exact sums and the divisor.
  logic                    s2_valid_r;
  logic [1:0]              s2_kind_r;
  logic                    s2_dz_r;
  logic signed [SUM_W-1:0] sum_re_r, sum_im_r;
  logic [PROD_W-1:0]       den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= s1_kind_r;
      s2_dz_r   <= s1_dz_r;
      den_r     <= PROD_W'($unsigned(q_rr_r)) + PROD_W'($unsigned(q_ii_r));
      case (s1_kind_r)
        OP_MUL: begin
          sum_re_r <= SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
          sum_im_r <= SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
        end
        OP_DIV: begin
          sum_re_r <= SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
          sum_im_r <= SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
        end
        default: begin
          sum_re_r <= SUM_W'(as_re_r);
          sum_im_r <= SUM_W'(as_im_r);
        end
      endcase
    end
  end

  // Stage 3: rescale and saturate non-divide results; set up the division.
  // Quotients of 2^W or more are flagged here, so the divider needs W bits only.
  logic                    s3_valid_r;
  cau_side_t               s3_side_r;
  logic [PROD_W-1:0]       s3_rem_re_r, s3_rem_im_r, s3_den_r;
  logic [W-1:0]            s3_low_re_r, s3_low_im_r;

  logic signed [SUM_W-1:0] v_re, v_im;
  logic [W:0]              st_re, st_im;
  logic [SUM_W-1:0]        mag_re, mag_im;
  logic [DXW-1:0]          dvd_re, dvd_im;
  logic [CW-1:0]           den_cmp;
  cau_side_t               side_nxt;

  always_comb begin
    v_re    = (s2_kind_r == OP_MUL) ? (sum_re_r >>> FRAC_BITS_P) : sum_re_r;
    v_im    = (s2_kind_r == OP_MUL) ? (sum_im_r >>> FRAC_BITS_P) : sum_im_r;
    st_re   = cau_sat(v_re);
    st_im   = cau_sat(v_im);
    mag_re  = sum_re_r[SUM_W-1] ? SUM_W'(-sum_re_r) : SUM_W'(sum_re_r);
    mag_im  = sum_im_r[SUM_W-1] ? SUM_W'(-sum_im_r) : SUM_W'(sum_im_r);
    dvd_re  = DXW'(mag_re) << FRAC_BITS_P;
    dvd_im  = DXW'(mag_im) << FRAC_BITS_P;
    den_cmp = CW'(den_r) << W;
    side_nxt.is_div = (s2_kind_r == OP_DIV);
    side_nxt.dz     = s2_dz_r;
    side_nxt.neg_re = sum_re_r[SUM_W-1];
    side_nxt.neg_im = sum_im_r[SUM_W-1];
    side_nxt.big_re = CW'(dvd_re) >= den_cmp;
    side_nxt.big_im = CW'(dvd_im) >= den_cmp;
    side_nxt.ovf    = st_re[W] | st_im[W];
    side_nxt.re     = st_re[W-1:0];
    side_nxt.im     = st_im[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r   <= side_nxt;
      s3_rem_re_r <= PROD_W'(dvd_re >> W);
      s3_rem_im_r <= PROD_W'(dvd_im >> W);
      s3_low_re_r <= dvd_re[W-1:0];
      s3_low_im_r <= dvd_im[W-1:0];
      s3_den_r    <= den_r;
    end
  end

  // Divider stages.
  logic      d_valid;
  cau_side_t d_side;
  logic [W-1:0] d_q_re, d_q_im;

  cau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_valid_r),
    .in_side   (s3_side_r),
    .in_rem_re (s3_rem_re_r),
    .in_rem_im (s3_rem_im_r),
    .in_low_re (s3_low_re_r),
    .in_low_im (s3_low_im_r),
    .in_den    (s3_den_r),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_q_re  (d_q_re),
    .out_q_im  (d_q_im)
  );

  // Output stage: sign and saturate quotients, then register the result.
  logic         sat_re, sat_im;
  logic [W-1:0] dv_re, dv_im;
  cau_out_t     out_nxt;
  logic         out_valid_r;
  cau_out_t     out_data_r;

  always_comb begin
    sat_re = d_side.big_re || (d_side.neg_re ? (d_q_re[W-1] && |d_q_re[W-2:0]) : d_q_re[W-1]);
    sat_im = d_side.big_im || (d_side.neg_im ? (d_q_im[W-1] && |d_q_im[W-2:0]) : d_q_im[W-1]);
    if (sat_re) begin
      dv_re = d_side.neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      dv_re = d_side.neg_re ? W'(-d_q_re) : d_q_re;
    end
    if (sat_im) begin
      dv_im = d_side.neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      dv_im = d_side.neg_im ? W'(-d_q_im) : d_q_im;
    end
    if (!d_side.is_div) begin
      out_nxt.res_re         = d_side.re;
      out_nxt.res_im         = d_side.im;
      out_nxt.overflow       = d_side.ovf;
      out_nxt.divide_by_zero = 1'b0;
    end else if (d_side.dz) begin
      out_nxt.res_re         = '0;
      out_nxt.res_im         = '0;
      out_nxt.overflow       = 1'b0;
      out_nxt.divide_by_zero = 1'b1;
    end else begin
      out_nxt.res_re         = dv_re;
      out_nxt.res_im         = dv_im;
      out_nxt.overflow       = sat_re | sat_im;
      out_nxt.divide_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/cau_div.sv
// Pipelined restoring divider for the real and imaginary quotients.
module cau_div import cau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  cau_side_t             in_side,
  input  logic [PROD_W-1:0]     in_rem_re,
  input  logic [PROD_W-1:0]     in_rem_im,
  input  logic [DATA_WIDTH-1:0] in_low_re,
  input  logic [DATA_WIDTH-1:0] in_low_im,
  input  logic [PROD_W-1:0]     in_den,
  output logic                  out_valid,
  output cau_side_t             out_side,
  output logic [DATA_WIDTH-1:0] out_q_re,
  output logic [DATA_WIDTH-1:0] out_q_im
);

  localparam int STEPS = 4;
  localparam int NST   = (DATA_WIDTH + STEPS - 1) / STEPS;

  logic                  valid_r  [NST];
  cau_side_t             side_r   [NST];
  logic [PROD_W-1:0]     rem_re_r [NST];
  logic [PROD_W-1:0]     rem_im_r [NST];
  logic [DATA_WIDTH-1:0] low_re_r [NST];
  logic [DATA_WIDTH-1:0] low_im_r [NST];
  logic [DATA_WIDTH-1:0] q_re_r   [NST];
  logic [DATA_WIDTH-1:0] q_im_r   [NST];
  logic [PROD_W-1:0]     den_r    [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                  v_in;
    cau_side_t             sd_in;
    logic [PROD_W-1:0]     rre_in, rim_in, den_in;
    logic [DATA_WIDTH-1:0] lre_in, lim_in, qre_in, qim_in;
    logic [PROD_W-1:0]     rre_nxt, rim_nxt;
    logic [DATA_WIDTH-1:0] lre_nxt, lim_nxt, qre_nxt, qim_nxt;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign sd_in  = in_side;
      assign rre_in = in_rem_re;
      assign rim_in = in_rem_im;
      assign lre_in = in_low_re;
      assign lim_in = in_low_im;
      assign qre_in = '0;
      assign qim_in = '0;
      assign den_in = in_den;
    end else begin : g_next
      assign v_in   = valid_r[s-1];
      assign sd_in  = side_r[s-1];
      assign rre_in = rem_re_r[s-1];
      assign rim_in = rem_im_r[s-1];
      assign lre_in = low_re_r[s-1];
      assign lim_in = low_im_r[s-1];
      assign qre_in = q_re_r[s-1];
      assign qim_in = q_im_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      logic [PROD_W:0] st;
      rre_nxt = rre_in;
      rim_nxt = rim_in;
      lre_nxt = lre_in;
      lim_nxt = lim_in;
      qre_nxt = qre_in;
      qim_nxt = qim_in;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < DATA_WIDTH) begin
          st      = cau_step(rre_nxt, lre_nxt[DATA_WIDTH-1], den_in);
          rre_nxt = st[PROD_W-1:0];
          qre_nxt = {qre_nxt[DATA_WIDTH-2:0], st[PROD_W]};
          lre_nxt = {lre_nxt[DATA_WIDTH-2:0], 1'b0};
          st      = cau_step(rim_nxt, lim_nxt[DATA_WIDTH-1], den_in);
          rim_nxt = st[PROD_W-1:0];
          qim_nxt = {qim_nxt[DATA_WIDTH-2:0], st[PROD_W]};
          lim_nxt = {lim_nxt[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s]   <= sd_in;
        rem_re_r[s] <= rre_nxt;
        rem_im_r[s] <= rim_nxt;
        low_re_r[s] <= lre_nxt;
        low_im_r[s] <= lim_nxt;
        q_re_r[s]   <= qre_nxt;
        q_im_r[s]   <= qim_nxt;
        den_r[s]    <= den_in;
      end
    end
  end

  assign out_valid = valid_r[NST-1];
  assign out_side  = side_r[NST-1];
  assign out_q_re  = q_re_r[NST-1];
  assign out_q_im  = q_im_r[NST-1];

endmodule

FILE: rtl/cau_chk.sv
// Port-level assertion checker for the complex arithmetic unit, with its bind.
module cau_chk import cau_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input cau_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input cau_out_t out_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input is only held off when a result is waiting on a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A divide by zero gives zero parts and no overflow.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflow)
    else $error("divide by zero result not cleared");

  // A reset clears out_valid, so the output shows no result straight after reset:
  // after reset the first result needs an input first.
  a_no_invent: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind complex_arithmetic_unit_core cau_chk u_cau_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
